// ===== sv/explicit_free_list_allocator_top_macros.svh =====
// Assertion macros for the free-list allocator checker.
`ifndef EXPLICIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define EXPLICIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define EFLA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("efla check failed");
`define EFLA_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("efla check failed");
`endif

// ===== sv/efla_pkg.sv =====
package efla_pkg;
    localparam int ADDR_W = 16;
    localparam int WORD_W = 17;
    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;

    typedef enum logic [2:0] {
        SEL_ZERO, SEL_HEAD, SEL_NEXT, SEL_PREV, SEL_SIZE
    } t_wsel;

    typedef struct packed {
        logic              rd_en;
        logic [WORD_W-1:0] rd_addr;
        logic              wr_en;
        logic [WORD_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_mem_cmd;
endpackage

// ===== sv/efla_heap_mem.sv =====
module efla_heap_mem #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                  i_clk,
    input  efla_pkg::t_mem_cmd    i_cmd,
    output logic [efla_pkg::WORD_W-1:0] o_rd_data
);
    import efla_pkg::*;
    localparam int DEPTH = HEAP_BYTES / 8;
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_q;
    logic              rd_in, wr_in;
    logic [IW-1:0]     rd_i, wr_i;

    assign rd_in = (i_cmd.rd_addr[WORD_W-1:3] < (WORD_W-3)'(DEPTH));
    assign wr_in = (i_cmd.wr_addr[WORD_W-1:3] < (WORD_W-3)'(DEPTH));
    assign rd_i  = i_cmd.rd_addr[IW+2:3];
    assign wr_i  = i_cmd.wr_addr[IW+2:3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_in) begin
            r_mem[wr_i] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_q <= rd_in ? r_mem[rd_i] : '0;
        end
    end
    assign o_rd_data = r_q;
endmodule

// ===== sv/efla_ctrl.sv =====
module efla_ctrl #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_action,
    input  logic [15:0]                 i_request_bytes,
    input  logic [15:0]                 i_payload_address,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [15:0]                 o_result_address,
    output logic                        o_success,
    output efla_pkg::t_mem_cmd          o_cmd,
    input  logic [efla_pkg::WORD_W-1:0] i_rd_data
);
    import efla_pkg::*;
    localparam int DEPTH = HEAP_BYTES / 8;
    localparam int KW = $clog2(DEPTH + 1);
    localparam logic [WORD_W-1:0] HB = WORD_W'(HEAP_BYTES);

    // Sequencer steps; read steps wait for the registered read data.
    typedef enum logic [5:0] {
        S_IDLE, S_DISP,
        A_RD, A_RW, A_CHK,
        A_SP0, A_SP1, A_SP2, A_SP3, A_SP4, A_SP5,
        U_RN, U_RNW, U_RP, U_RPW, U_W0, U_W1,
        A_TG_R, A_TG_RW, A_TG0, A_TG1, A_GROW, A_GT1,
        F_RS, F_RSW, F_T0, F_T1, F_P0, F_P1, F_P2,
        F_RN, F_RNW, F_RNS, F_RNSW, F_RN2, F_RN2W, F_MR0, F_MR1,
        F_L0, F_LRF, F_LRFW, F_LRH, F_LRHW, F_LRS, F_LRSW, F_ML0, F_ML1,
        S_OUT
    } t_state;

    t_state            r_st, r_ret;
    logic [WORD_W-1:0] r_head, r_first, r_last, r_brk;
    logic [WORD_W-1:0] r_need, r_node, r_blk, r_cur, r_n, r_p, r_un, r_sz, r_nb, r_pb;
    logic [KW-1:0]     r_k;
    logic [15:0]       r_res;
    logic              r_ok, r_ov, r_mrg;
    logic [15:0]       r_ores;
    logic              r_ook;
    logic [15:0]       r_req, r_pa;
    logic [1:0]        r_act;
    t_mem_cmd          c;
    logic [WORD_W-1:0] rsz, need_c;

    assign rsz = i_rd_data & {{(WORD_W-1){1'b1}}, 1'b0};
    assign need_c = ((WORD_W'((r_req > 16'd16) ? r_req : 16'd16) + WORD_W'(31))
                    & ~WORD_W'(15));
    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_result_address = r_ores;
    assign o_success = r_ook;
    assign o_cmd = c;

    always_comb begin
        c = '0;
        unique case (r_st)
            A_RD:    begin c.rd_en = 1'b1; c.rd_addr = r_node - 17'd8; end
            A_SP0:   begin c.wr_en = 1'b1; c.wr_addr = r_blk + r_need + 17'd8;
                           c.wr_data = r_head; end
            A_SP1:   begin c.wr_en = 1'b1; c.wr_addr = r_blk + r_need + 17'd16; end
            A_SP2:   begin c.wr_en = (r_head != '0); c.wr_addr = r_head + 17'd8;
                           c.wr_data = (r_blk + r_need + 17'd8) & 17'hFFFF; end
            A_SP3:   begin c.wr_en = 1'b1; c.wr_addr = r_blk; c.wr_data = r_need | 17'd1; end
            A_SP4:   begin c.wr_en = 1'b1; c.wr_addr = r_blk + r_need - 17'd8;
                           c.wr_data = r_need | 17'd1; end
            A_SP5:   begin c.wr_en = 1'b1; c.wr_addr = r_blk + r_need;
                           c.wr_data = r_cur - r_need; end
            A_TG_R:  begin c.wr_en = 1'b1; c.wr_addr = r_blk + r_cur - 17'd8;
                           c.wr_data = r_cur - r_need; c.rd_en = 1'b1; c.rd_addr = r_blk; end
            A_TG0:   begin c.wr_en = 1'b1; c.wr_addr = r_blk; c.wr_data = r_sz | 17'd1; end
            A_TG1:   begin c.wr_en = 1'b1; c.wr_addr = r_blk + r_sz - 17'd8;
                           c.wr_data = r_sz | 17'd1; end
            A_GROW:  begin c.wr_en = 1'b1; c.wr_addr = r_blk; c.wr_data = r_need | 17'd1; end
            A_GT1:   begin c.wr_en = 1'b1; c.wr_addr = r_blk + r_need - 17'd8;
                           c.wr_data = r_need | 17'd1; end
            A_CHK:   begin c.rd_en = 1'b1; c.rd_addr = r_node; end
            U_RN:    begin c.rd_en = 1'b1; c.rd_addr = r_un; end
            U_RP:    begin c.rd_en = 1'b1; c.rd_addr = r_un + 17'd8; end
            U_W0:    begin
                if (r_un == r_head) begin
                    c.wr_en = (r_n != '0); c.wr_addr = r_n + 17'd8;
                end else begin
                    c.wr_en = (r_p != '0); c.wr_addr = r_p; c.wr_data = r_n;
                end
            end
            U_W1:    begin c.wr_en = (r_un != r_head) && (r_n != '0);
                           c.wr_addr = r_n + 17'd8; c.wr_data = r_p; end
            F_RS:    begin c.rd_en = 1'b1; c.rd_addr = r_blk; end
            F_T0:    begin c.wr_en = 1'b1; c.wr_addr = r_blk; c.wr_data = r_sz; end
            F_T1:    begin c.wr_en = 1'b1; c.wr_addr = r_blk + r_sz - 17'd8; c.wr_data = r_sz; end
            F_P0:    begin c.wr_en = 1'b1; c.wr_addr = r_blk + 17'd8; c.wr_data = r_head; end
            F_P1:    begin c.wr_en = 1'b1; c.wr_addr = r_blk + 17'd16; end
            F_P2:    begin c.wr_en = (r_head != '0); c.wr_addr = r_head + 17'd8;
                           c.wr_data = (r_blk + 17'd8) & 17'hFFFF; end
            F_RN:    begin c.rd_en = 1'b1; c.rd_addr = r_blk + r_sz; end
            F_MR0:   begin c.wr_en = 1'b1; c.wr_addr = r_blk; c.wr_data = r_sz + r_cur; end
            F_MR1:   begin c.wr_en = 1'b1; c.wr_addr = r_blk + r_sz + r_cur - 17'd8;
                           c.wr_data = r_sz + r_cur; end
            F_LRF:   begin c.rd_en = 1'b1; c.rd_addr = r_blk - 17'd8; end
            F_LRH:   begin c.rd_en = 1'b1; c.rd_addr = r_pb; end
            F_LRS:   begin c.rd_en = 1'b1; c.rd_addr = r_blk; end
            F_ML0:   begin c.wr_en = 1'b1; c.wr_addr = r_pb; c.wr_data = r_sz + r_cur; end
            F_ML1:   begin c.wr_en = 1'b1; c.wr_addr = r_pb + r_sz + r_cur - 17'd8;
                           c.wr_data = r_sz + r_cur; end
            default: c = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ret <= S_IDLE; r_ov <= 1'b0;
            r_head <= '0; r_first <= '0; r_last <= '0; r_brk <= 17'd8;
        end else begin
            if (r_ov && !i_stall && r_st != S_OUT) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_act <= i_action; r_req <= i_request_bytes;
                    r_pa <= i_payload_address; r_st <= S_DISP;
                end
                S_DISP: begin
                    r_res <= '0; r_ok <= 1'b1; r_mrg <= 1'b0;
                    priority case (r_act)
                        ACT_INIT: begin
                            r_brk <= 17'd8; r_head <= '0; r_first <= '0; r_last <= '0;
                            r_st <= S_OUT;
                        end
                        ACT_ALLOC: begin
                            r_need <= need_c; r_node <= r_head; r_k <= '0;
                            r_st <= A_CHK;
                        end
                        ACT_FREE: begin
                            r_blk <= {1'b0, r_pa} - 17'd8;
                            r_st <= (r_pa == '0) ? S_OUT : F_RS;
                        end
                        default: begin r_ok <= 1'b0; r_st <= S_OUT; end
                    endcase
                end
                // A_CHK: test loop end; reads node's next link for later.
                A_CHK: begin
                    if (r_node == '0 || r_k == KW'(DEPTH)) begin
                        if ({1'b0, r_brk} + {1'b0, r_need} > {1'b0, HB}) begin
                            r_ok <= 1'b0; r_st <= S_OUT;
                        end else begin
                            r_blk <= r_brk; r_brk <= r_brk + r_need;
                            if (r_first == '0) r_first <= r_brk & 17'hFFFF;
                            r_last <= r_brk & 17'hFFFF;
                            r_st <= A_GROW;
                        end
                    end else begin
                        r_blk <= r_node - 17'd8; r_st <= A_RD;
                    end
                end
                A_RD: begin r_n <= i_rd_data & 17'hFFFF; r_st <= A_RW; end
                A_RW: begin
                    r_cur <= rsz;
                    if (rsz >= r_need) begin
                        r_st <= (rsz >= r_need + 17'd32) ? A_SP0 : A_TG_R;
                        r_un <= r_node; r_ret <= A_TG_R;
                        if (rsz < r_need + 17'd32) r_st <= U_RN;
                    end else begin
                        r_node <= r_n; r_k <= r_k + 1'b1; r_st <= A_CHK;
                    end
                end
                A_SP0: r_st <= A_SP1;
                A_SP1: r_st <= A_SP2;
                A_SP2: begin r_head <= (r_blk + r_need + 17'd8) & 17'hFFFF; r_st <= A_SP3; end
                A_SP3: r_st <= A_SP4;
                A_SP4: r_st <= A_SP5;
                A_SP5: begin
                    if (r_blk == r_last) r_last <= (r_blk + r_need) & 17'hFFFF;
                    r_st <= A_TG_R;
                    r_mrg <= 1'b1;
                end
                A_TG_R: begin
                    if (r_mrg) begin
                        r_mrg <= 1'b0; r_st <= U_RN;
                    end else begin
                        r_st <= A_TG_RW;
                    end
                end
                A_TG_RW: begin r_sz <= rsz; r_st <= A_TG0; end
                A_TG0: r_st <= A_TG1;
                A_TG1: begin r_res <= 16'(r_blk + 17'd8); r_st <= S_OUT; end
                A_GROW: r_st <= A_GT1;
                A_GT1: begin r_res <= 16'(r_blk + 17'd8); r_st <= S_OUT; end
                // unlink subroutine on r_un, returns to r_ret
                U_RN:  r_st <= U_RNW;
                U_RNW: begin r_n <= i_rd_data & 17'hFFFF; r_st <= U_RP; end
                U_RP:  r_st <= U_RPW;
                U_RPW: begin r_p <= i_rd_data & 17'hFFFF; r_st <= U_W0; end
                U_W0:  r_st <= U_W1;
                U_W1:  begin
                    if (r_un == r_head) r_head <= r_n;
                    r_st <= r_ret;
                end
                F_RS:  r_st <= F_RSW;
                F_RSW: begin r_sz <= rsz; r_st <= F_T0; end
                F_T0:  r_st <= F_T1;
                F_T1:  r_st <= F_P0;
                F_P0:  r_st <= F_P1;
                F_P1:  r_st <= F_P2;
                F_P2:  begin
                    r_head <= (r_blk + 17'd8) & 17'hFFFF;
                    r_st <= (r_blk < r_last) ? F_RN : F_L0;
                end
                F_RN:  r_st <= F_RNW;
                F_RNW: begin
                    r_nb <= r_blk + r_sz; r_cur <= rsz;
                    r_st <= i_rd_data[0] ? F_L0 : F_MR0;
                end
                F_MR0: r_st <= F_MR1;
                F_MR1: begin
                    r_sz <= r_sz + r_cur;
                    if (r_nb == r_last) r_last <= r_blk & 17'hFFFF;
                    r_un <= r_nb + 17'd8; r_ret <= F_L0; r_st <= U_RN;
                end
                F_RNS, F_RNSW, F_RN2, F_RN2W: r_st <= F_L0;
                F_L0:  r_st <= (r_blk > r_first) ? F_LRF : S_OUT;
                F_LRF: r_st <= F_LRFW;
                F_LRFW: begin r_pb <= r_blk - rsz; r_st <= F_LRH; end
                F_LRH: r_st <= F_LRHW;
                F_LRHW: begin
                    r_cur <= rsz;
                    r_st <= i_rd_data[0] ? S_OUT : F_LRS;
                end
                F_LRS: r_st <= F_LRSW;
                F_LRSW: begin r_sz <= rsz; r_st <= F_ML0; end
                F_ML0: r_st <= F_ML1;
                F_ML1: begin
                    if (r_blk == r_last) r_last <= r_pb & 17'hFFFF;
                    r_un <= r_blk + 17'd8; r_ret <= S_OUT; r_st <= U_RN;
                end
                S_OUT: if (!r_ov || !i_stall) begin
                    r_ores <= r_res; r_ook <= r_ok;
                    r_ov <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/explicit_free_list_allocator_top.sv =====
// channel | valid   | stall   | fields
// in      | i_valid | o_stall | i_action, i_request_bytes, i_payload_address
// out     | o_valid | i_stall | o_result_address, o_success
// A new word is taken only once the previous one is done. How long a word runs depends
// on the action: allocate on the free-list nodes visited and on failure, break growth,
// fit or split; free on its merges.
// The free-list walk and the heap memory with registered reads set the step count.
// Synchronous active-low reset clears list head and block marks and sets break to 8; heap
// contents are not cleared. A stalled result holds in its own register; the next
// word runs meanwhile and waits in its last step until that register frees.
module explicit_free_list_allocator_top #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_payload_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_result_address,
    output logic        o_success
);
    import efla_pkg::*;
    t_mem_cmd          cmd;
    logic [WORD_W-1:0] rd_data;

    efla_ctrl #(.HEAP_BYTES(HEAP_BYTES)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_action, .i_request_bytes,
        .i_payload_address, .o_valid, .i_stall, .o_result_address, .o_success,
        .o_cmd(cmd), .i_rd_data(rd_data)
    );
    efla_heap_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
        .i_clk, .i_cmd(cmd), .o_rd_data(rd_data)
    );
endmodule

// ===== sv/efla_checker.sv =====
`include "explicit_free_list_allocator_top_macros.svh"
module efla_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_result_address,
    input logic        o_success
);
    `EFLA_ASSERT(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_result_address))
    `EFLA_ASSERT(a_take, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall)
    `EFLA_ASSERT(a_addr, i_clk, i_rst_n, o_valid && o_result_address != 16'd0 |-> o_success)
    `EFLA_ASSERT_NR(a_rst, i_clk, !i_rst_n |=> !o_valid)
endmodule

bind explicit_free_list_allocator_top efla_checker u_chk (.*);
